/* hw/rtl/one_at_a_time_hash_fold_core_defines.svh */
// Assertion macros for the one-at-a-time hash core.
// No dependencies; included by the top level only.
`ifndef ONE_AT_A_TIME_HASH_FOLD_CORE_DEFINES_SVH
`define ONE_AT_A_TIME_HASH_FOLD_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define OAAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, disabled during reset
`define OAAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define OAAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OAAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/oaat_pkg.sv */
// Shared widths for the one-at-a-time hash core.
// No dependencies.
package oaat_pkg;

	localparam int HashW = 32;
	localparam int ByteW = 8;
	localparam int FoldW = 6;

	typedef logic [HashW-1:0] hash_t;
	typedef logic [ByteW-1:0] byte_t;
	typedef logic [FoldW-1:0] fold_t;

endpackage

/* hw/rtl/oaat_in_if.sv */
// Key byte channel: valid/ready plus one key item.
// Depends on oaat_pkg.
interface oaat_in_if;
	logic                 valid;
	logic                 ready;
	oaat_pkg::byte_t      key_byte;
	logic                 byte_present;
	logic                 key_end;

	modport source (output valid, output key_byte, output byte_present, output key_end,
		input ready);
	modport sink (input valid, input key_byte, input byte_present, input key_end,
		output ready);
endinterface

/* hw/rtl/oaat_out_if.sv */
// Result channel: valid/ready plus hash and bucket index.
// Depends on oaat_pkg.
interface oaat_out_if;
	logic                 valid;
	logic                 ready;
	oaat_pkg::hash_t      hash_value;
	oaat_pkg::hash_t      bucket_index;

	modport source (output valid, output hash_value, output bucket_index, input ready);
	modport sink (input valid, input hash_value, input bucket_index, output ready);
endinterface

/* hw/rtl/oaat_mix.sv */
// Input register and per-byte mixing loop holding the running hash.
// Depends on oaat_pkg and oaat_in_if.
module oaat_mix (
	input  logic             clk,
	input  logic             arst_n,
	oaat_in_if.sink          key,
	output logic             mix_valid,
	input  logic             mix_ready,
	output oaat_pkg::hash_t  mix_hash
);

	logic            valid_s1;
	oaat_pkg::byte_t byte_s1;
	logic            present_s1;
	logic            end_s1;
	oaat_pkg::hash_t running_hash_q;
	oaat_pkg::hash_t h_add;
	oaat_pkg::hash_t h_mul;
	oaat_pkg::hash_t h_next;
	logic            leave;

	// add byte, shift-add 10, xor-shift 6; hash held when no byte is present
	always_comb begin
		h_add  = running_hash_q + {{(oaat_pkg::HashW-oaat_pkg::ByteW){1'b0}}, byte_s1};
		h_mul  = h_add + (h_add << 10);
		h_next = present_s1 ? (h_mul ^ (h_mul >> 6)) : running_hash_q;
	end

	// non-end items always retire; end items wait for the finalizer
	assign leave     = !end_s1 || mix_ready;
	assign key.ready = !valid_s1 || leave;
	assign mix_valid = valid_s1 && end_s1;
	assign mix_hash  = h_next;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			running_hash_q <= '0;
		end else begin
			if (valid_s1 && leave)
				running_hash_q <= end_s1 ? '0 : h_next;
			if (key.ready)
				valid_s1 <= key.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (key.ready && key.valid) begin
			byte_s1    <= key.key_byte;
			present_s1 <= key.byte_present;
			end_s1     <= key.key_end;
		end
	end

endmodule

/* hw/rtl/oaat_final.sv */
// Two-stage finalization: shift-add 3 / xor-shift 11, then shift-add 15.
// Depends on oaat_pkg.
module oaat_final (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  oaat_pkg::hash_t  up_hash,
	output logic             dn_valid,
	input  logic             dn_ready,
	output oaat_pkg::hash_t  dn_hash
);

	logic            valid_s2;
	logic            valid_s3;
	oaat_pkg::hash_t hash_s2;
	oaat_pkg::hash_t hash_s3;
	oaat_pkg::hash_t h_mul3;
	logic            ready_s2;
	logic            ready_s3;

	// first finalize step
	always_comb begin
		h_mul3 = hash_s2 + (hash_s2 << 3);
	end

	assign ready_s3 = !valid_s3 || dn_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;
	assign dn_valid = valid_s3;
	// last finalize step
	assign dn_hash  = hash_s3 + (hash_s3 << 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2)
				valid_s2 <= up_valid;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && up_valid)
			hash_s2 <= up_hash;
		if (ready_s3 && valid_s2)
			hash_s3 <= h_mul3 ^ (h_mul3 >> 11);
	end

endmodule

/* hw/rtl/oaat_fold.sv */
// Final hash register, xor-fold to the bucket index and result register.
// Depends on oaat_pkg and oaat_out_if.
module oaat_fold (
	input  logic             clk,
	input  logic             arst_n,
	input  oaat_pkg::fold_t  fold_bits,
	input  logic             up_valid,
	output logic             up_ready,
	input  oaat_pkg::hash_t  up_hash,
	oaat_out_if.source       result
);

	localparam int HashW = oaat_pkg::HashW;
	localparam int SelW  = $clog2(HashW);

	// hash bits that land on bucket bit i for chunk width b
	function automatic logic [HashW-1:0] fold_sel(input int b, input int i);
		logic [HashW-1:0] m;
		int               c;
		m = '0;
		c = 0;
		for (int j = 0; j < HashW; j++) begin
			if (c == i)
				m[j] = 1'b1;
			c = (c == b - 1) ? 0 : c + 1;
		end
		return m;
	endfunction

	logic            valid_s4;
	oaat_pkg::hash_t hash_s4;
	oaat_pkg::hash_t fold_w [HashW];
	oaat_pkg::hash_t bucket;
	logic            valid_q;
	logic            ready_s4;

	// one constant fold network per chunk width, then select by width
	assign fold_w[0] = '0;
	for (genvar b = 1; b < HashW; b++) begin : g_width
		for (genvar i = 0; i < HashW; i++) begin : g_bit
			if (i < b) begin : g_used
				localparam logic [HashW-1:0] SelMask = fold_sel(b, i);
				assign fold_w[b][i] = ^(hash_s4 & SelMask);
			end else begin : g_zero
				assign fold_w[b][i] = 1'b0;
			end
		end
	end

	always_comb begin
		if (fold_bits >= oaat_pkg::FoldW'(HashW))
			bucket = hash_s4;
		else
			bucket = fold_w[fold_bits[SelW-1:0]];
	end

	assign ready_s4     = !valid_s4 || !valid_q || result.ready;
	assign up_ready     = !valid_s4 || ready_s4;
	assign result.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (!valid_q || result.ready)
				valid_q <= valid_s4;
			if (up_ready)
				valid_s4 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			hash_s4 <= up_hash;
		if (valid_s4 && (!valid_q || result.ready)) begin
			result.hash_value   <= hash_s4;
			result.bucket_index <= bucket;
		end
	end

endmodule

/* hw/rtl/one_at_a_time_hash_fold_core.sv */
// Streaming Jenkins one-at-a-time hash with an xor-folded bucket index. The core
// takes one key item (a byte, an end mark, or both) per clock unless an end item
// waits for the finalizer; the running hash loops through a single register
// (add, shift-add, xor-shift). Items that end a key produce one result via the
// mix register, two finalize stages, the final hash register and the result
// register, the latter set by the fold network. Items without an end mark
// produce no result. Backpressure on the result channel fills the pipeline
// bubble by bubble before the key channel stalls.
// Write cfg_wdata (fold width) only while no key is in flight.
`include "one_at_a_time_hash_fold_core_defines.svh"

module one_at_a_time_hash_fold_core (
	input  logic                    clk,
	input  logic                    arst_n,
	oaat_in_if.sink                 key,
	oaat_out_if.source              result,
	input  logic                    cfg_we,
	input  logic [oaat_pkg::FoldW-1:0] cfg_wdata
);

	oaat_pkg::fold_t fold_bits_q;
	logic            mix_valid;
	logic            mix_ready;
	oaat_pkg::hash_t mix_hash;
	logic            fin_valid;
	logic            fin_ready;
	oaat_pkg::hash_t fin_hash;

	// fold width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_bits_q <= '0;
		end else if (cfg_we) begin
			fold_bits_q <= cfg_wdata;
		end
	end

	oaat_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.mix_valid (mix_valid),
		.mix_ready (mix_ready),
		.mix_hash  (mix_hash)
	);

	oaat_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mix_valid),
		.up_ready (mix_ready),
		.up_hash  (mix_hash),
		.dn_valid (fin_valid),
		.dn_ready (fin_ready),
		.dn_hash  (fin_hash)
	);

	oaat_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.fold_bits (fold_bits_q),
		.up_valid  (fin_valid),
		.up_ready  (fin_ready),
		.up_hash   (fin_hash),
		.result    (result)
	);

	// fold width zero gives a zero bucket
	`OAAT_ASSERT_IMPL(a_fold_zero, clk, arst_n,
		result.valid && (fold_bits_q == '0), result.bucket_index == '0)
	// full-width fold passes the hash through
	`OAAT_ASSERT_IMPL(a_fold_full, clk, arst_n,
		result.valid && (fold_bits_q >= oaat_pkg::FoldW'(oaat_pkg::HashW)),
		result.bucket_index == result.hash_value)
	// one-bit fold leaves only bit 0
	`OAAT_ASSERT_IMPL(a_fold_one, clk, arst_n,
		result.valid && (fold_bits_q == oaat_pkg::FoldW'(1)),
		result.bucket_index[oaat_pkg::HashW-1:1] == '0)

endmodule
